/* hdl/pvgs_pkg.sv */
`default_nettype none

package pvgs_pkg;

	localparam int GRID_WIDTH  = 256;
	localparam int GRID_HEIGHT = 128;

	localparam int DATA_W     = 24;
	localparam int FACTOR_W   = 16;
	localparam int OUT_COL_W  = 8;
	localparam int OUT_ROW_W  = 7;
	localparam int COL_W      = $clog2(GRID_WIDTH);
	localparam int ROW_W      = $clog2(GRID_HEIGHT);
	localparam int COL_CNT_W  = (COL_W > OUT_COL_W) ? COL_W : OUT_COL_W;
	localparam int ROW_CNT_W  = (ROW_W > OUT_ROW_W) ? ROW_W : OUT_ROW_W;
	localparam int OPND_W     = DATA_W + 2;
	localparam int PROD_W     = OPND_W + FACTOR_W + 1;
	localparam int SUM_W      = 48;
	localparam int FRAC_SHIFT = 16;
	localparam int Q_W        = SUM_W - FRAC_SHIFT;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [FACTOR_W-1:0] PRESSURE_LOSS_RST = 16'd65529;
	localparam logic [FACTOR_W-1:0] PRESSURE_STEP_RST = 16'd19661;
	localparam logic [FACTOR_W-1:0] VELOCITY_LOSS_RST = 16'd65470;
	localparam logic [FACTOR_W-1:0] VELOCITY_STEP_RST = 16'd26214;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [OPND_W-1:0] opnd_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [FACTOR_W-1:0]      factor_t;
	typedef logic [COL_CNT_W-1:0]     col_cnt_t;
	typedef logic [ROW_CNT_W-1:0]     row_cnt_t;
	typedef logic [OUT_ROW_W-1:0]     out_row_t;
	typedef logic [OUT_COL_W-1:0]     out_col_t;

	typedef enum logic [1:0] {
		REG_PRESSURE_LOSS = 2'd0,
		REG_PRESSURE_STEP = 2'd1,
		REG_VELOCITY_LOSS = 2'd2,
		REG_VELOCITY_STEP = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		col_cnt_t col;
		out_row_t row;
		out_row_t row_up;
		logic     border;
		logic     has_up;
		logic     last_row;
		logic     last_col;
		data_t    op;
		data_t    ovx;
		data_t    ovy;
		data_t    left_vx;
	} cell_t;

	typedef struct packed {
		data_t p;
		data_t vx;
		data_t vy;
	} line_t;

	localparam sum_t ROUND_HALF = SUM_W'(32768);
	localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(8388607);
	localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(8388608);

	function automatic prod_t mul_f(input opnd_t a, input factor_t f);
		return PROD_W'(a) * PROD_W'($signed({1'b0, f}));
	endfunction

	function automatic data_t round_sat(input sum_t v);
		sum_t t;
		logic signed [Q_W-1:0] q;
		t = v + ROUND_HALF;
		q = t[SUM_W-1:FRAC_SHIFT];
		if (q > Q_MAX) begin
			return Q_MAX[DATA_W-1:0];
		end else if (q < Q_MIN) begin
			return Q_MIN[DATA_W-1:0];
		end
		return q[DATA_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hdl/pvgs_front.sv */
`default_nettype none

module pvgs_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            frame_start,
	input  wire pvgs_pkg::data_t old_pressure,
	input  wire pvgs_pkg::data_t old_vel_x,
	input  wire pvgs_pkg::data_t old_vel_y,
	input  wire logic            q_full,
	output logic                 q_push,
	output pvgs_pkg::cell_t      q_word
);
	import pvgs_pkg::*;

	col_cnt_t col_q;
	row_cnt_t row_q;
	data_t    left_q;
	col_cnt_t c;
	row_cnt_t r;
	row_cnt_t r_up;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		c    = frame_start ? '0 : col_q;
		r    = frame_start ? '0 : row_q;
		r_up = r - ROW_CNT_W'(1);
		q_word.col      = c;
		q_word.row      = r[OUT_ROW_W-1:0];
		q_word.row_up   = r_up[OUT_ROW_W-1:0];
		q_word.border   = (r == '0) || (c == '0);
		q_word.has_up   = (r != '0);
		q_word.last_row = (r == ROW_CNT_W'(GRID_HEIGHT - 1));
		q_word.last_col = (c == COL_CNT_W'(GRID_WIDTH - 1));
		q_word.op       = old_pressure;
		q_word.ovx      = old_vel_x;
		q_word.ovy      = old_vel_y;
		q_word.left_vx  = left_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (q_push) begin
			left_q <= old_vel_x;
			if (q_word.last_col) begin
				col_q <= '0;
				row_q <= q_word.last_row ? '0 : r + ROW_CNT_W'(1);
			end else begin
				col_q <= c + COL_CNT_W'(1);
				row_q <= r;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/pvgs_queue.sv */
`default_nettype none

module pvgs_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pvgs_pkg::cell_t push_word,
	output logic                 full,
	input  wire logic            pop,
	output pvgs_pkg::cell_t      head,
	output logic                 empty
);
	import pvgs_pkg::*;

	cell_t                slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [FIFO_CW-1:0]   cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign head    = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	function automatic logic [FIFO_AW-1:0] nxt(input logic [FIFO_AW-1:0] p);
		return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= nxt(wr_q);
			end
			if (do_pop) begin
				rd_q <= nxt(rd_q);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + FIFO_CW'(1);
				2'b01:   cnt_q <= cnt_q - FIFO_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/pvgs_back.sv */
`default_nettype none

module pvgs_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic [1:0]        cfg_index,
	input  wire pvgs_pkg::factor_t cfg_data,
	input  wire pvgs_pkg::cell_t   head,
	input  wire logic              q_empty,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output pvgs_pkg::out_col_t     cell_col,
	output pvgs_pkg::out_row_t     cell_row,
	output pvgs_pkg::data_t        new_pressure,
	output pvgs_pkg::data_t        new_vel_x,
	output pvgs_pkg::data_t        new_vel_y,
	output logic                   frame_last
);
	import pvgs_pkg::*;

	localparam out_row_t LAST_ROW_LO = OUT_ROW_W'(GRID_HEIGHT - 1);
	localparam out_col_t LAST_COL_LO = OUT_COL_W'(GRID_WIDTH - 1);

	factor_t p_loss_q;
	factor_t p_step_q;
	factor_t v_loss_q;
	factor_t v_step_q;

	line_t line_mem [GRID_WIDTH];

	logic  en;
	logic  ld_ok;
	logic  has_any;
	logic  two_words;
	logic  emit;
	logic  fin;
	logic  ph_q;
	logic  sel_b;

	logic  v_s1, v_s2, v_s3, v_s4;
	cell_t item_s1, item_s2, item_s3, item_s4;
	line_t rd_up_s1;
	line_t rd_right_s1;
	logic [COL_W-1:0] addr_up;
	logic [COL_W-1:0] addr_right;

	opnd_t inflow;
	opnd_t dx;
	opnd_t dy;

	data_t up_p_s2;
	prod_t pr_op_s2, pr_in_s2, pr_pvx_s2, pr_pvy_s2, pr_dx_s2, pr_svx_s2, pr_svy_s2;

	data_t np;
	data_t nvx;
	data_t svx;
	data_t svy;

	data_t np_s3, up_p_s3, nvx_s3, svx_s3, svy_s3;
	prod_t pr_pvy_s3;

	data_t np_s4, up_p_s4, nvx_s4, svx_s4, svy_s4;
	prod_t pr_pvy_s4, pr_dy_s4;
	data_t nvy;

	logic     out_valid_q;
	out_col_t cell_col_q;
	out_row_t cell_row_q;
	data_t    new_pressure_q;
	data_t    new_vel_x_q;
	data_t    new_vel_y_q;
	logic     frame_last_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_loss_q <= PRESSURE_LOSS_RST;
			p_step_q <= PRESSURE_STEP_RST;
			v_loss_q <= VELOCITY_LOSS_RST;
			v_step_q <= VELOCITY_STEP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PRESSURE_LOSS: p_loss_q <= cfg_data;
				REG_PRESSURE_STEP: p_step_q <= cfg_data;
				REG_VELOCITY_LOSS: v_loss_q <= cfg_data;
				REG_VELOCITY_STEP: v_step_q <= cfg_data;
				default:           p_loss_q <= p_loss_q;
			endcase
		end
	end

	// advance control
	always_comb begin
		ld_ok     = !out_valid_q || !out_stall;
		has_any   = item_s4.has_up || item_s4.last_row;
		two_words = item_s4.has_up && item_s4.last_row;
		emit      = v_s4 && has_any && ld_ok;
		fin       = v_s4 && (!has_any || (ld_ok && (ph_q || !two_words)));
		en        = !v_s4 || fin;
		q_pop     = en && !q_empty;
		sel_b     = !item_s4.has_up || ph_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			ph_q <= 1'b0;
		end else begin
			if (en) begin
				v_s1 <= !q_empty;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
			if (fin) begin
				ph_q <= 1'b0;
			end else if (emit) begin
				ph_q <= 1'b1;
			end
		end
	end

	// line buffer: previous row's velocities and new pressures
	always_comb begin
		addr_up    = head.col[COL_W-1:0];
		addr_right = head.last_col ? '0 : addr_up + COL_W'(1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_up_s1    <= line_mem[addr_up];
			rd_right_s1 <= line_mem[addr_right];
			item_s1     <= head;
		end
		if (en && v_s2) begin
			line_mem[item_s2.col[COL_W-1:0]] <= '{p: np, vx: item_s2.ovx, vy: item_s2.ovy};
		end
	end

	// s1: products
	always_comb begin
		inflow = OPND_W'(item_s1.left_vx) - OPND_W'(item_s1.ovx)
			+ OPND_W'(rd_up_s1.vy) - OPND_W'(item_s1.ovy);
		dx     = OPND_W'(rd_up_s1.p) - OPND_W'(rd_right_s1.p);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2   <= item_s1;
			up_p_s2   <= rd_up_s1.p;
			pr_op_s2  <= mul_f(OPND_W'(item_s1.op), p_loss_q);
			pr_in_s2  <= mul_f(inflow, p_step_q);
			pr_pvx_s2 <= mul_f(OPND_W'(rd_up_s1.vx), v_loss_q);
			pr_pvy_s2 <= mul_f(OPND_W'(rd_up_s1.vy), v_loss_q);
			pr_dx_s2  <= mul_f(dx, v_step_q);
			pr_svx_s2 <= mul_f(OPND_W'(item_s1.ovx), v_loss_q);
			pr_svy_s2 <= mul_f(OPND_W'(item_s1.ovy), v_loss_q);
		end
	end

	// s2: new pressure, x velocity of the cell above, last-row decay
	always_comb begin
		np  = item_s2.border ? round_sat(SUM_W'(pr_op_s2))
			: round_sat(SUM_W'(pr_op_s2) + SUM_W'(pr_in_s2));
		nvx = item_s2.last_col ? round_sat(SUM_W'(pr_pvx_s2))
			: round_sat(SUM_W'(pr_pvx_s2) + SUM_W'(pr_dx_s2));
		svx = round_sat(SUM_W'(pr_svx_s2));
		svy = round_sat(SUM_W'(pr_svy_s2));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s3   <= item_s2;
			np_s3     <= np;
			up_p_s3   <= up_p_s2;
			nvx_s3    <= nvx;
			svx_s3    <= svx;
			svy_s3    <= svy;
			pr_pvy_s3 <= pr_pvy_s2;
		end
	end

	// s3: vertical pressure difference product
	assign dy = OPND_W'(up_p_s3) - OPND_W'(np_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4   <= item_s3;
			np_s4     <= np_s3;
			up_p_s4   <= up_p_s3;
			nvx_s4    <= nvx_s3;
			svx_s4    <= svx_s3;
			svy_s4    <= svy_s3;
			pr_pvy_s4 <= pr_pvy_s3;
			pr_dy_s4  <= mul_f(dy, v_step_q);
		end
	end

	// s4: y velocity of the cell above, word select
	assign nvy = item_s4.last_col ? round_sat(SUM_W'(pr_pvy_s4))
		: round_sat(SUM_W'(pr_pvy_s4) + SUM_W'(pr_dy_s4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			cell_col_q <= item_s4.col[OUT_COL_W-1:0];
			if (sel_b) begin
				cell_row_q     <= item_s4.row;
				new_pressure_q <= np_s4;
				new_vel_x_q    <= svx_s4;
				new_vel_y_q    <= svy_s4;
				frame_last_q   <= item_s4.last_col;
			end else begin
				cell_row_q     <= item_s4.row_up;
				new_pressure_q <= up_p_s4;
				new_vel_x_q    <= nvx_s4;
				new_vel_y_q    <= nvy;
				frame_last_q   <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign cell_col     = cell_col_q;
	assign cell_row     = cell_row_q;
	assign new_pressure = new_pressure_q;
	assign new_vel_x    = new_vel_x_q;
	assign new_vel_y    = new_vel_y_q;
	assign frame_last   = frame_last_q;

`ifndef SYNTHESIS
	a_phase_two_words: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q |-> (v_s4 && item_s4.has_up && item_s4.last_row))
		else $error("second-word phase set without a two-word cell");

	a_phase_follows_first: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && two_words && !ph_q && ld_ok) |=> (ph_q && out_valid_q))
		else $error("first of two words not followed by second phase");

	a_last_position: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_last_q) |->
		(cell_row_q == LAST_ROW_LO && cell_col_q == LAST_COL_LO))
		else $error("frame_last on a cell other than the final one");

	a_hold_owed: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && has_any && !ld_ok) |=> (v_s4 && $stable(item_s4)))
		else $error("stage 4 word dropped while output stalled");
`endif

endmodule

`default_nettype wire

/* hdl/pressure_velocity_grid_step_top.sv */
// Input words pass the queue, stages s1 to s4 and the output register to the result.
// Throughput: one cell per cycle without stalls; last-row cells hold s4 for two words.
// Row 0 cells give no result; other rows give the cell one row up, one frame row late.
// Rate set by the single-port output register and the 4-deep front/back queue.
// Reset: counters and queue clear, config registers take their defaults;
// the line buffer is not cleared and needs no clearing pass.
`default_nettype none

module pressure_velocity_grid_step_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire pvgs_pkg::factor_t cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              frame_start,
	input  wire pvgs_pkg::data_t   old_pressure,
	input  wire pvgs_pkg::data_t   old_vel_x,
	input  wire pvgs_pkg::data_t   old_vel_y,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output pvgs_pkg::out_col_t     cell_col,
	output pvgs_pkg::out_row_t     cell_row,
	output pvgs_pkg::data_t        new_pressure,
	output pvgs_pkg::data_t        new_vel_x,
	output pvgs_pkg::data_t        new_vel_y,
	output logic                   frame_last
);
	import pvgs_pkg::*;

	logic  q_full;
	logic  q_push;
	cell_t q_word;
	logic  q_pop;
	logic  q_empty;
	cell_t q_head;

	assign cfg_ready = 1'b1;

	pvgs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_start  (frame_start),
		.old_pressure (old_pressure),
		.old_vel_x    (old_vel_x),
		.old_vel_y    (old_vel_y),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_word       (q_word)
	);

	pvgs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_word),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	pvgs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head         (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cell_col     (cell_col),
		.cell_row     (cell_row),
		.new_pressure (new_pressure),
		.new_vel_x    (new_vel_x),
		.new_vel_y    (new_vel_y),
		.frame_last   (frame_last)
	);

endmodule

`default_nettype wire

/* tb/sv/pressure_velocity_grid_step_top_tb.sv */
`default_nettype none

module pressure_velocity_grid_step_top_tb;

	import pvgs_pkg::*;

	localparam int     STALL_LIMIT  = 2000;
	localparam int     SETTLE_TICKS = 20;
	localparam longint Q14_MAX      = 8388607;
	localparam longint Q14_MIN      = -8388608;

	typedef struct {
		logic  frame_start;
		data_t p;
		data_t vx;
		data_t vy;
	} cell_word_t;

	typedef struct {
		out_col_t col;
		out_row_t row;
		data_t    p;
		data_t    vx;
		data_t    vy;
		logic     last;
	} cell_result_t;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     cfg_valid    = 1'b0;
	logic     cfg_ready;
	logic [1:0] cfg_index  = '0;
	factor_t  cfg_data     = '0;
	logic     in_valid     = 1'b0;
	logic     in_stall;
	logic     frame_start  = 1'b0;
	data_t    old_pressure = '0;
	data_t    old_vel_x    = '0;
	data_t    old_vel_y    = '0;
	logic     out_valid;
	logic     out_stall    = 1'b0;
	out_col_t cell_col;
	out_row_t cell_row;
	data_t    new_pressure;
	data_t    new_vel_x;
	data_t    new_vel_y;
	logic     frame_last;

	pressure_velocity_grid_step_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_start  (frame_start),
		.old_pressure (old_pressure),
		.old_vel_x    (old_vel_x),
		.old_vel_y    (old_vel_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cell_col     (cell_col),
		.cell_row     (cell_row),
		.new_pressure (new_pressure),
		.new_vel_x    (new_vel_x),
		.new_vel_y    (new_vel_y),
		.frame_last   (frame_last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// grid state mirror
	factor_t p_loss = PRESSURE_LOSS_RST;
	factor_t p_step = PRESSURE_STEP_RST;
	factor_t v_loss = VELOCITY_LOSS_RST;
	factor_t v_step = VELOCITY_STEP_RST;
	int      col_pos = 0;
	int      row_pos = 0;
	data_t   left_vx = '0;
	data_t   line_p  [GRID_WIDTH];
	data_t   line_vx [GRID_WIDTH];
	data_t   line_vy [GRID_WIDTH];

	cell_word_t   cells_to_send [$];
	cell_result_t owed_results  [$];
	cell_word_t   on_wire;
	int           cells_queued  = 0;
	int           cells_taken   = 0;
	int           mismatches    = 0;
	int           send_idle_pct = 0;
	int           sink_stall_pct = 0;
	int           quiet_cycles  = 0;

	function automatic data_t q14_round_clip(input longint acc);
		longint q;
		q = (acc + 64'sd32768) >>> 16;
		if (q > Q14_MAX)
			q = Q14_MAX;
		else if (q < Q14_MIN)
			q = Q14_MIN;
		return data_t'(q);
	endfunction

	function automatic void step_grid(input cell_word_t w);
		longint       kpl, kps, kvl, kvs, op, ovx, ovy, pp, acc_x, acc_y;
		data_t        np;
		int           c, r;
		cell_result_t res;
		kpl = p_loss;
		kps = p_step;
		kvl = v_loss;
		kvs = v_step;
		if (w.frame_start) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		op = w.p;
		ovx = w.vx;
		ovy = w.vy;

		if (r == 0 || c == 0) begin
			np = q14_round_clip(op * kpl);
		end else begin
			np = q14_round_clip(op * kpl +
				((longint'(left_vx) - ovx) + (longint'(line_vy[c]) - ovy)) * kps);
		end

		// cell one row up
		if (r >= 1) begin
			pp = line_p[c];
			acc_x = longint'(line_vx[c]) * kvl;
			acc_y = longint'(line_vy[c]) * kvl;
			if (c != GRID_WIDTH - 1) begin
				acc_x += (pp - longint'(line_p[c + 1])) * kvs;
				acc_y += (pp - longint'(np)) * kvs;
			end
			res.col = out_col_t'(c);
			res.row = out_row_t'(r - 1);
			res.p = data_t'(pp);
			res.vx = q14_round_clip(acc_x);
			res.vy = q14_round_clip(acc_y);
			res.last = 1'b0;
			owed_results.push_back(res);
		end

		line_vx[c] = w.vx;
		line_vy[c] = w.vy;
		line_p[c] = np;
		left_vx = w.vx;

		// bottom row, decay only
		if (r == GRID_HEIGHT - 1) begin
			res.col = out_col_t'(c);
			res.row = out_row_t'(r);
			res.p = np;
			res.vx = q14_round_clip(ovx * kvl);
			res.vy = q14_round_clip(ovy * kvl);
			res.last = (c == GRID_WIDTH - 1);
			owed_results.push_back(res);
		end

		col_pos = c + 1;
		if (col_pos >= GRID_WIDTH) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= GRID_HEIGHT)
				row_pos = 0;
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				step_grid(on_wire);
				cells_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (cells_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_wire = cells_to_send.pop_front();
					in_valid <= 1'b1;
					frame_start <= on_wire.frame_start;
					old_pressure <= on_wire.p;
					old_vel_x <= on_wire.vx;
					old_vel_y <= on_wire.vy;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		cell_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$error("unexpected result word col %0d row %0d", cell_col, cell_row);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					check_field("cell_col", want.col, cell_col);
					check_field("cell_row", want.row, cell_row);
					check_field("new_pressure", want.p, new_pressure);
					check_field("new_vel_x", want.vx, new_vel_x);
					check_field("new_vel_y", want.vy, new_vel_y);
					check_field("frame_last", want.last, frame_last);
				end
			end
			out_stall <= ($urandom_range(99) < sink_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic data_t corner_value(input int k);
		case (k % 5)
			0: return data_t'(Q14_MAX);
			1: return data_t'(Q14_MIN);
			2: return '0;
			3: return '1;
			default: return data_t'(1);
		endcase
	endfunction

	function automatic data_t rand_q14();
		int s;
		s = $urandom_range(4095);
		case ($urandom_range(9))
			0: return data_t'(Q14_MAX);
			1: return data_t'(Q14_MIN);
			2: return '0;
			3: return '1;
			4, 5: return data_t'(s - 2048);
			default: return data_t'($urandom);
		endcase
	endfunction

	task automatic push_cell(input logic fs, input data_t p, input data_t vx, input data_t vy);
		cell_word_t w;
		w.frame_start = fs;
		w.p = p;
		w.vx = vx;
		w.vy = vy;
		cells_to_send.push_back(w);
		cells_queued++;
	endtask

	// runs of cells, most continuing the frame, a few restarting it
	task automatic queue_runs(input int count);
		int n;
		int len;
		logic fs;
		n = 0;
		while (n < count) begin
			if ($urandom_range(4) == 0)
				len = $urandom_range(1, GRID_WIDTH - 1);
			else
				len = $urandom_range(300, 600);
			if (len > count - n)
				len = count - n;
			fs = ($urandom_range(7) == 0);
			for (int i = 0; i < len; i++)
				push_cell(fs && i == 0, rand_q14(), rand_q14(), rand_q14());
			n += len;
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input factor_t val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_PRESSURE_LOSS: p_loss = val;
			REG_PRESSURE_STEP: p_step = val;
			REG_VELOCITY_LOSS: v_loss = val;
			REG_VELOCITY_STEP: v_step = val;
		endcase
	endtask

	task automatic write_all(input factor_t pl, input factor_t ps, input factor_t vl,
		input factor_t vs);
		write_reg(REG_PRESSURE_LOSS, pl);
		write_reg(REG_PRESSURE_STEP, ps);
		write_reg(REG_VELOCITY_LOSS, vl);
		write_reg(REG_VELOCITY_STEP, vs);
	endtask

	task automatic wait_drained();
		while (cells_taken != cells_queued || owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset factors, a frame start running into row 1
		send_idle_pct = 7;
		sink_stall_pct = 46;
		for (int i = 0; i < 20; i++)
			push_cell(i == 0, corner_value(i), corner_value(i + 2), corner_value(3 * i + 1));
		for (int i = 20; i < 300; i++)
			push_cell(1'b0, rand_q14(), rand_q14(), rand_q14());
		wait_drained();

		send_idle_pct = 46;
		sink_stall_pct = 7;
		write_all('1, '1, '1, '1);
		queue_runs(150);
		wait_drained();

		write_all('0, '0, '0, '0);
		queue_runs(100);
		wait_drained();

		send_idle_pct = 0;
		sink_stall_pct = 0;
		write_all('0, '1, '1, '0);
		queue_runs(150);
		wait_drained();

		repeat (2) begin
			write_all(factor_t'($urandom), factor_t'($urandom), factor_t'($urandom),
				factor_t'($urandom));
			queue_runs(100);
			wait_drained();
		end

		if (mismatches == 0 && owed_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
